[hw/rtl/med_pkg.sv]
`default_nettype none

package med_pkg;

    typedef logic [7:0] t_byte;

    localparam logic MODE_Q = 1'b0;
    localparam logic MODE_B = 1'b1;

    localparam logic [1:0] Q_HELD_NONE  = 2'd0;
    localparam logic [1:0] Q_HELD_EQ    = 2'd1;
    localparam logic [1:0] Q_HELD_DIGIT = 2'd2;

    localparam t_byte CHAR_UNDERSCORE = 8'h5F;
    localparam t_byte CHAR_EQUALS     = 8'h3D;
    localparam t_byte CHAR_SPACE      = 8'h20;
    localparam t_byte CHAR_PLUS       = 8'h2B;
    localparam t_byte CHAR_SLASH      = 8'h2F;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] q_held_count;
        t_byte      q_held_char;
        t_byte      b_partial;
        logic [2:0] b_bit_count;
        logic       b_done;
    } t_word_state;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;
    } t_result;

    localparam t_word_state WORD_STATE_CLEAR = '0;

    // Bit 4 is set when the character is not an ASCII hex digit.
    function automatic logic [4:0] f_hex_value(t_byte c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

    // Bit 6 is set when the character is outside the base64 alphabet.
    function automatic logic [6:0] f_b64_value(t_byte c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == CHAR_PLUS) begin
            v = 7'd62;
        end else if (c == CHAR_SLASH) begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/med_step.sv]
`default_nettype none

module med_step (
    input  wire logic                 i_mode,
    input  wire med_pkg::t_word_state i_state,
    input  wire med_pkg::t_byte       i_text_char,
    input  wire logic                 i_word_end,
    output med_pkg::t_word_state      o_state,
    output med_pkg::t_result          o_result
);

    typedef struct packed {
        med_pkg::t_word_state st;
        med_pkg::t_result     res;
    } t_work;

    function automatic t_work f_emit(t_work w, med_pkg::t_byte b);
        t_work x;
        x = w;
        if (x.res.count != 2'd3) begin
            x.res.bytes[x.res.count] = b;
            x.res.count = x.res.count + 2'd1;
        end
        return x;
    endfunction

    function automatic t_work f_q_plain(t_work w, med_pkg::t_byte c);
        t_work x;
        x = w;
        if (c == med_pkg::CHAR_UNDERSCORE) begin
            x = f_emit(x, med_pkg::CHAR_SPACE);
        end else if (c == med_pkg::CHAR_EQUALS) begin
            x.st.q_held_count = med_pkg::Q_HELD_EQ;
        end else begin
            x = f_emit(x, c);
        end
        return x;
    endfunction

    logic [4:0] w_hex;
    logic [4:0] w_held_hex;
    logic [6:0] w_b64;
    logic [2:0] w_k;
    t_work      w_work;

    assign w_hex      = med_pkg::f_hex_value(i_text_char);
    assign w_held_hex = med_pkg::f_hex_value(i_state.q_held_char);
    assign w_b64      = med_pkg::f_b64_value(i_text_char);

    always_comb begin
        w_work.st  = i_state;
        w_work.res = '0;
        w_k        = i_state.b_bit_count;
        if (i_mode == med_pkg::MODE_Q) begin
            case (i_state.q_held_count)
                med_pkg::Q_HELD_NONE: begin
                    w_work = f_q_plain(w_work, i_text_char);
                end
                med_pkg::Q_HELD_EQ: begin
                    if (!w_hex[4]) begin
                        w_work.st.q_held_count = med_pkg::Q_HELD_DIGIT;
                        w_work.st.q_held_char  = i_text_char;
                    end else begin
                        w_work = f_emit(w_work, med_pkg::CHAR_EQUALS);
                        w_work.st.q_held_count = med_pkg::Q_HELD_NONE;
                        w_work = f_q_plain(w_work, i_text_char);
                    end
                end
                default: begin
                    if (!w_hex[4]) begin
                        w_work = f_emit(w_work, {w_held_hex[3:0], w_hex[3:0]});
                        w_work.st.q_held_count = med_pkg::Q_HELD_NONE;
                    end else begin
                        w_work = f_emit(w_work, med_pkg::CHAR_EQUALS);
                        w_work = f_emit(w_work, i_state.q_held_char);
                        w_work.st.q_held_count = med_pkg::Q_HELD_NONE;
                        w_work = f_q_plain(w_work, i_text_char);
                    end
                end
            endcase
            if (i_word_end) begin
                if (w_work.st.q_held_count != med_pkg::Q_HELD_NONE) begin
                    w_work = f_emit(w_work, med_pkg::CHAR_EQUALS);
                end
                if (w_work.st.q_held_count == med_pkg::Q_HELD_DIGIT) begin
                    w_work = f_emit(w_work, w_work.st.q_held_char);
                end
            end
        end else if (!i_state.b_done) begin
            if (i_text_char == med_pkg::CHAR_EQUALS) begin
                w_work.st.b_done = 1'b1;
            end else if (!w_b64[6]) begin
                if (w_k >= 3'd2) begin
                    w_k = w_k - 3'd2;
                    w_work = f_emit(w_work,
                        i_state.b_partial | (8'({2'b00, w_b64[5:0]}) >> w_k));
                    w_work.st.b_partial =
                        8'({2'b00, w_b64[5:0]}) << (4'd8 - {1'b0, w_k});
                    w_work.st.b_bit_count = w_k;
                end else begin
                    w_work.st.b_partial = i_state.b_partial |
                        (8'({2'b00, w_b64[5:0]}) << (w_k + 3'd2));
                    w_work.st.b_bit_count = w_k + 3'd6;
                end
            end
        end
        if (i_word_end) begin
            w_work.st = med_pkg::WORD_STATE_CLEAR;
        end
    end

    assign o_state  = w_work.st;
    assign o_result = w_work.res;

endmodule

`default_nettype wire

[hw/rtl/mime_encoded_word_decoder_top.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_text_char, i_word_end
// result    out        o_valid / i_stall      o_decoded_byte, o_run_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_decode_mode
//
// One character is taken per cycle while it causes at most one result.
// A character that causes two or three results holds the input while the result
// buffer drains one byte per cycle.
// Reset is synchronous and active low; it selects Q decoding and clears the word.
// A stall on the result side stops the input once the buffer holds its last byte.

module mime_encoded_word_decoder_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire med_pkg::t_byte i_text_char,
    input  wire logic           i_word_end,
    output logic                o_valid,
    input  wire logic           i_stall,
    output med_pkg::t_byte      o_decoded_byte,
    output logic                o_run_last,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_decode_mode
);

    logic                 r_mode;
    med_pkg::t_word_state r_state;
    med_pkg::t_word_state n_state;
    med_pkg::t_result     w_result;
    logic [med_pkg::MAX_RESULTS-1:0][7:0] r_bytes;
    logic [1:0]           r_cnt;
    logic                 w_accept;
    logic                 w_take;
    logic                 w_cfg_write;

    med_step u_step (
        .i_mode      (r_mode),
        .i_state     (r_state),
        .i_text_char (i_text_char),
        .i_word_end  (i_word_end),
        .o_state     (n_state),
        .o_result    (w_result)
    );

    assign o_cfg_ready    = 1'b1;
    assign w_cfg_write    = i_cfg_valid && o_cfg_ready;
    assign o_valid        = (r_cnt != 2'd0);
    assign o_stall        = (r_cnt > 2'd1) || ((r_cnt == 2'd1) && i_stall);
    assign w_accept       = i_valid && !o_stall;
    assign w_take         = o_valid && !i_stall;
    assign o_decoded_byte = r_bytes[0];
    assign o_run_last     = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= med_pkg::MODE_Q;
            r_state <= med_pkg::WORD_STATE_CLEAR;
        end else if (w_cfg_write) begin
            r_mode  <= i_cfg_decode_mode;
            r_state <= med_pkg::WORD_STATE_CLEAR;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_accept) begin
            r_cnt <= w_result.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bytes <= w_result.bytes;
        end else if (w_take) begin
            r_bytes <= {8'h00, r_bytes[med_pkg::MAX_RESULTS-1:1]};
        end
    end

    a_accept_only_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_take))
        else $error("input request taken while results were still queued");

    a_b_mode_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_mode == med_pkg::MODE_B)) |=> (r_cnt <= 2'd1))
        else $error("base64 request produced more than one byte");

    a_last_take_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (r_cnt == 2'd1) && !w_accept) |=> !o_valid)
        else $error("result buffer not empty after its last byte was taken");

    a_multi_result_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_result.count > 2'd1)) |=> o_stall)
        else $error("input not held while a burst of results drains");

endmodule

`default_nettype wire
